// ===== sv/ctt_pkg.sv =====
// Shared types and constants for the config text tokenizer.
// No dependencies; imported by the tokenizer and its checker.
`timescale 1ns / 1ps

package ctt_pkg;

    localparam int NUM_CFG    = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_RESULT = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_OPEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_CLOSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_OPEN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_CLOSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSIGN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_OPEN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST_CLOSE    = 3'd6;

    localparam logic [7:0] CFG_RESET [NUM_CFG] = '{8'd91, 8'd93, 8'd123, 8'd125,
                                                   8'd61, 8'd40, 8'd41};

    // token kinds
    localparam logic [3:0] KIND_BODY        = 4'd0;
    localparam logic [3:0] KIND_STR_END     = 4'd1;
    localparam logic [3:0] KIND_GROUP_OPEN  = 4'd2;
    localparam logic [3:0] KIND_GROUP_CLOSE = 4'd3;
    localparam logic [3:0] KIND_ASSIGN      = 4'd4;
    localparam logic [3:0] KIND_LIST_OPEN   = 4'd5;
    localparam logic [3:0] KIND_LIST_CLOSE  = 4'd6;
    localparam logic [3:0] KIND_END         = 4'd7;
    localparam logic [3:0] KIND_BAD_CHAR    = 4'd8;
    localparam logic [3:0] KIND_UNTERM      = 4'd9;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [15:0] LINE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] body;
        logic [9:0] len;
        logic       trunc;
    } result_t;

    // byte allowed inside an unquoted string
    function automatic logic valid_char(input logic [7:0] c);
        logic sym;
        sym = (c == 8'h24) || (c == 8'h2F) || (c == 8'h40) || (c == 8'h5F)
           || (c == 8'h2E) || (c == 8'h3A) || (c == 8'h7E) || (c == 8'h2D)
           || (c == 8'h25) || (c == 8'h23) || (c == 8'h5E);
        return sym || (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A) || (c > 8'd127);
    endfunction

endpackage

// ===== sv/config_text_tokenizer.sv =====
// Config text tokenizer: byte-in, token-out lexer with comment skipping.
// Depends on ctt_pkg.
`timescale 1ns / 1ps
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+-----------------------------------------
//  text in  | text_valid  | text_stall  | text_byte, final_byte
//  token out| token_valid | token_stall | token_kind, body_byte, string_length,
//           |             |             | truncated, line_number, run_end
//  config   | cfg_write   | -           | cfg_index, cfg_data
//
//  A byte is lexed in the cycle it is taken; its 0..3 results land in the
//  result bundle register and leave one per cycle while token_stall is low
//  (bound by the single output port); the next byte waits for the last one.
//  Bytes with at most one result stream at one per cycle when not stalled.
//  Reset puts the lexer between tokens at line 1 and loads default chars.
//  text_stall rises only while the bundle holds results not yet taken.

module config_text_tokenizer #(
    parameter int MAX_TOKEN_BYTES = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      text_valid,
    output logic                      text_stall,
    input  logic [7:0]                text_byte,
    input  logic                      final_byte,
    output logic                      token_valid,
    input  logic                      token_stall,
    output logic [3:0]                token_kind,
    output logic [7:0]                body_byte,
    output logic [9:0]                string_length,
    output logic                      truncated,
    output logic [15:0]               line_number,
    output logic                      run_end,
    input  logic                      cfg_write,
    input  logic [ctt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                cfg_data
);
    import ctt_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_TOKEN_BYTES - 1);

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_QUOTED,
        MODE_UNQUOTED
    } mode_t;

    logic [7:0]        cfg_reg [NUM_CFG];
    mode_t             mode_reg, mode_next;
    logic              esc_reg, esc_next;
    logic signed [7:0] depth_reg, depth_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [15:0]       line_reg, line_next, line_bump;

    result_t           bun_reg [MAX_RESULT];
    result_t           res [MAX_RESULT];
    logic [1:0]        bun_cnt_reg, bun_idx_reg, res_cnt;
    logic [15:0]       bun_line_reg;

    logic in_fire, out_fire, last_out;

    assign token_valid = (bun_cnt_reg != 2'd0);
    assign last_out    = (bun_idx_reg == bun_cnt_reg - 2'd1);
    assign out_fire    = token_valid && !token_stall;
    assign text_stall  = token_valid && !(out_fire && last_out);
    assign in_fire     = text_valid && !text_stall;

    assign token_kind    = bun_reg[bun_idx_reg].kind;
    assign body_byte     = bun_reg[bun_idx_reg].body;
    assign string_length = bun_reg[bun_idx_reg].len;
    assign truncated     = bun_reg[bun_idx_reg].trunc;
    assign line_number   = bun_line_reg;
    assign run_end       = last_out;

    // lexer step for the byte on the input
    always_comb
    begin
        logic [1:0]        n;
        logic              end_str, do_between, keep, skip;
        logic signed [7:0] d;
        logic [LEN_W-1:0]  base_len;
        logic              tok_hit;

        n          = 2'd0;
        end_str    = 1'b0;
        do_between = 1'b0;
        keep       = 1'b0;
        skip       = 1'b0;
        tok_hit    = 1'b0;
        for (int i = 0; i < MAX_RESULT; i++)
        begin
            res[i] = '0;
        end
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        depth_next = depth_reg;
        len_next   = len_reg;

        line_bump = (text_byte == CH_LF && line_reg != LINE_MAX) ? line_reg + 16'd1
                                                                 : line_reg;

        unique case (mode_reg)
            MODE_QUOTED:
            begin
                if (!esc_reg && text_byte == CH_DQUOTE)
                begin
                    end_str = 1'b1;
                end
                else
                begin
                    esc_next = (text_byte == CH_BSLASH);
                    keep     = (text_byte != CH_BSLASH);
                end
            end
            MODE_UNQUOTED:
            begin
                if (valid_char(text_byte))
                begin
                    keep = 1'b1;
                end
                else
                begin
                    end_str    = 1'b1;
                    do_between = 1'b1;
                end
            end
            default:
            begin
                do_between = 1'b1;
            end
        endcase

        if (end_str)
        begin
            res[n] = '{kind: KIND_STR_END, body: 8'd0, len: 10'(len_reg),
                       trunc: (len_reg >= LEN_LIMIT)};
            n          = n + 2'd1;
            mode_next  = MODE_BETWEEN;
            depth_next = '0;
            len_next   = '0;
        end

        if (keep && len_reg < LEN_LIMIT)
        begin
            res[n]   = '{kind: KIND_BODY, body: text_byte, len: 10'd0, trunc: 1'b0};
            n        = n + 2'd1;
            len_next = len_reg + LEN_W'(1);
        end

        if (do_between)
        begin
            d        = end_str ? 8'sd0 : depth_reg;
            base_len = '0;
            skip = (text_byte == CH_SPACE) || (text_byte == CH_TAB)
                || (text_byte == CH_LF) || (d > 8'sd0)
                || (text_byte == cfg_reg[CFG_COMMENT_OPEN])
                || (d >= 8'sd0 && text_byte == cfg_reg[CFG_COMMENT_CLOSE]);
            if (skip)
            begin
                // open wins when both chars are equal
                if (text_byte == cfg_reg[CFG_COMMENT_OPEN])
                begin
                    depth_next = (d != 8'sd127) ? d + 8'sd1 : d;
                end
                else if (text_byte == cfg_reg[CFG_COMMENT_CLOSE])
                begin
                    depth_next = (d != -8'sd128) ? d - 8'sd1 : d;
                end
                else
                begin
                    depth_next = d;
                end
            end
            else
            begin
                depth_next = '0;
                for (int k = 2; k < NUM_CFG; k++)
                begin
                    if (!tok_hit && text_byte == cfg_reg[k])
                    begin
                        tok_hit = 1'b1;
                        res[n]  = '{kind: 4'(k), body: 8'd0, len: 10'd0, trunc: 1'b0};
                    end
                end
                priority if (tok_hit)
                begin
                    n = n + 2'd1;
                end
                else if (text_byte == CH_DQUOTE)
                begin
                    mode_next = MODE_QUOTED;
                    esc_next  = 1'b0;
                    len_next  = base_len;
                end
                else if (valid_char(text_byte))
                begin
                    // limit is at least one, so the opening byte is always kept
                    mode_next = MODE_UNQUOTED;
                    res[n]    = '{kind: KIND_BODY, body: text_byte, len: 10'd0,
                                  trunc: 1'b0};
                    n         = n + 2'd1;
                    len_next  = base_len + LEN_W'(1);
                end
                else
                begin
                    res[n] = '{kind: KIND_BAD_CHAR, body: text_byte, len: 10'd0,
                               trunc: 1'b0};
                    n      = n + 2'd1;
                end
            end
        end

        line_next = line_bump;

        if (final_byte)
        begin
            if (mode_next == MODE_UNQUOTED)
            begin
                res[n] = '{kind: KIND_STR_END, body: 8'd0, len: 10'(len_next),
                           trunc: (len_next >= LEN_LIMIT)};
                n      = n + 2'd1;
            end
            else if (mode_next == MODE_QUOTED)
            begin
                res[n] = '{kind: KIND_UNTERM, body: 8'd0, len: 10'd0, trunc: 1'b0};
                n      = n + 2'd1;
            end
            res[n]     = '{kind: KIND_END, body: 8'd0, len: 10'd0, trunc: 1'b0};
            n          = n + 2'd1;
            mode_next  = MODE_BETWEEN;
            esc_next   = 1'b0;
            depth_next = '0;
            len_next   = '0;
            line_next  = 16'd1;
        end

        res_cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
            mode_reg    <= MODE_BETWEEN;
            esc_reg     <= 1'b0;
            depth_reg   <= '0;
            len_reg     <= '0;
            line_reg    <= 16'd1;
            bun_cnt_reg <= 2'd0;
            bun_idx_reg <= 2'd0;
        end
        else
        begin
            if (cfg_write && cfg_index <= CFG_LIST_CLOSE)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end

            if (in_fire)
            begin
                mode_reg    <= mode_next;
                esc_reg     <= esc_next;
                depth_reg   <= depth_next;
                len_reg     <= len_next;
                line_reg    <= line_next;
                bun_cnt_reg <= res_cnt;
                bun_idx_reg <= 2'd0;
            end
            else if (out_fire)
            begin
                if (last_out)
                begin
                    bun_cnt_reg <= 2'd0;
                    bun_idx_reg <= 2'd0;
                end
                else
                begin
                    bun_idx_reg <= bun_idx_reg + 2'd1;
                end
            end
        end
    end

    // result bundle payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < MAX_RESULT; i++)
            begin
                bun_reg[i] <= res[i];
            end
            bun_line_reg <= line_bump;
        end
    end

endmodule

// ===== sv/ctt_checker.sv =====
// Port-level checks for the config text tokenizer, bound into config_text_tokenizer.
// Depends on ctt_pkg and config_text_tokenizer.
`timescale 1ns / 1ps

module ctt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        token_valid,
    input logic        token_stall,
    input logic [3:0]  token_kind,
    input logic [7:0]  body_byte,
    input logic [9:0]  string_length,
    input logic        truncated,
    input logic [15:0] line_number,
    input logic        run_end
);
    import ctt_pkg::*;

    // a held transaction stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_stall |=> token_valid && $stable(token_kind)
            && $stable(body_byte) && $stable(string_length) && $stable(line_number))
        else $error("token transaction changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> token_kind <= KIND_UNTERM)
        else $error("token kind out of range");

    // end of input is always the last result of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == KIND_END |-> run_end)
        else $error("end token not last of its run");

    a_body_fields: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind != KIND_STR_END |-> string_length == 10'd0 && !truncated)
        else $error("length fields set on a non string-end token");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> line_number != 16'd0)
        else $error("line number is zero");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);

// ===== verif/tb_config_text_tokenizer.sv =====
// Self-checking testbench for config_text_tokenizer: directed table, then random
// documents under several delimiter settings, with random gaps and output stalls.
// Depends on ctt_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_config_text_tokenizer;
    import ctt_pkg::*;

    localparam int TOK_MAX = 1024;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  body;
        logic [9:0]  len;
        logic        trunc;
        logic [15:0] line;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        logic [3:0] kind;
        logic [7:0] body;
    } stim_t;

    typedef enum logic [1:0] {LEX_GAP, LEX_QUOTED, LEX_BARE} lex_mode_t;

    // Hand-checked rows carry their expected kind/body; the rest go to the predictor.
    localparam stim_t DIR_TAB [25] = '{
        '{8'h7B, 1'b0, 1'b1, KIND_GROUP_OPEN,  8'h00},
        '{8'h7D, 1'b0, 1'b1, KIND_GROUP_CLOSE, 8'h00},
        '{8'h3D, 1'b0, 1'b1, KIND_ASSIGN,      8'h00},
        '{8'h28, 1'b0, 1'b1, KIND_LIST_OPEN,   8'h00},
        '{8'h29, 1'b0, 1'b1, KIND_LIST_CLOSE,  8'h00},
        '{8'h00, 1'b0, 1'b1, KIND_BAD_CHAR,    8'h00},
        '{8'h0D, 1'b0, 1'b1, KIND_BAD_CHAR,    8'h0D},
        '{8'hFF, 1'b0, 1'b1, KIND_BODY,        8'hFF},
        '{8'h0A, 1'b0, 1'b0, KIND_BODY, 8'h00},  // ends bare string, next line
        '{8'h5D, 1'b0, 1'b0, KIND_BODY, 8'h00},  // close at depth zero -> -1
        '{8'h5D, 1'b0, 1'b0, KIND_BODY, 8'h00},  // close no longer skipped
        '{8'h5B, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h7B, 1'b0, 1'b0, KIND_BODY, 8'h00},  // swallowed by comment
        '{8'h5D, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h22, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h5C, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h5C, 1'b0, 1'b0, KIND_BODY, 8'h00},  // escaped backslash re-arms escape
        '{8'h22, 1'b0, 1'b0, KIND_BODY, 8'h00},  // so this quote is kept
        '{8'h61, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h22, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h78, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h3D, 1'b0, 1'b0, KIND_BODY, 8'h00},  // string end plus assign
        '{8'h22, 1'b0, 1'b0, KIND_BODY, 8'h00},
        '{8'h7A, 1'b1, 1'b0, KIND_BODY, 8'h00},  // final inside quoted string
        '{8'h6B, 1'b1, 1'b0, KIND_BODY, 8'h00}   // final on a bare string start
    };

    localparam logic [7:0] BARE_SYMS [11] = '{8'h24, 8'h2F, 8'h40, 8'h5F, 8'h2E, 8'h3A,
                                              8'h7E, 8'h2D, 8'h25, 8'h23, 8'h5E};
    localparam logic [7:0] CFG_EDGE [NUM_CFG] = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                                                  8'h01, 8'hFE, 8'h0D};
    // open == close, token bytes shadowing a letter, the quote and a space
    localparam logic [7:0] CFG_ALIAS [NUM_CFG] = '{8'h2F, 8'h2F, 8'h61, CH_DQUOTE,
                                                   CH_BSLASH, 8'h2C, CH_SPACE};

    logic                 clk;
    logic                 rst_n;
    logic                 text_valid;
    logic                 text_stall;
    logic [7:0]           text_byte;
    logic                 final_byte;
    logic                 token_valid;
    logic                 token_stall;
    logic [3:0]           token_kind;
    logic [7:0]           body_byte;
    logic [9:0]           string_length;
    logic                 truncated;
    logic [15:0]          line_number;
    logic                 run_end;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    // side data travelling with each byte transaction
    logic       pin_typed;
    logic [3:0] pin_kind;
    logic [7:0] pin_body;

    // predictor state
    logic [7:0] cfg_chr [NUM_CFG];
    lex_mode_t  mode;
    bit         esc;
    int         depth;
    int         tok_len;
    int         line_cnt;
    tok_t       step_res[$];
    tok_t       token_q[$];

    int         fail_cnt;
    bit         no_idle;
    int         hold_left;
    int         free_left;
    logic [7:0] doc_q[$];
    logic [7:0] cfg_rand [NUM_CFG];

    config_text_tokenizer #(
        .MAX_TOKEN_BYTES(TOK_MAX)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .final_byte   (final_byte),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token_kind   (token_kind),
        .body_byte    (body_byte),
        .string_length(string_length),
        .truncated    (truncated),
        .line_number  (line_number),
        .run_end      (run_end),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic bit bare_ok(input logic [7:0] c);
        case (c)
            "$", "/", "@", "_", ".", ":", "~", "-", "%", "#", "^": return 1'b1;
            default: return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z")
                         || (c >= "a" && c <= "z") || c > 8'd127;
        endcase
    endfunction

    function automatic void emit_tok(input logic [3:0] kind, input logic [7:0] body,
                                     input int len, input bit trunc);
        tok_t t;
        t.kind  = kind;
        t.body  = body;
        t.len   = 10'(len);
        t.trunc = trunc;
        t.line  = 16'(line_cnt);
        t.last  = 1'b0;
        step_res.push_back(t);
    endfunction

    function automatic void keep_body(input logic [7:0] b);
        if (tok_len < TOK_MAX - 1)
        begin
            tok_len++;
            emit_tok(KIND_BODY, b, 0, 1'b0);
        end
    endfunction

    function automatic void close_string();
        emit_tok(KIND_STR_END, 8'h00, tok_len, tok_len >= TOK_MAX - 1);
        mode    = LEX_GAP;
        depth   = 0;
        tok_len = 0;
    endfunction

    function automatic void token_start(input logic [7:0] b);
        int k;
        if (b == CH_SPACE || b == CH_TAB || b == CH_LF || depth > 0
            || b == cfg_chr[CFG_COMMENT_OPEN]
            || (depth >= 0 && b == cfg_chr[CFG_COMMENT_CLOSE]))
        begin
            if (b == cfg_chr[CFG_COMMENT_OPEN])
            begin
                if (depth < 127) depth++;
            end
            else if (b == cfg_chr[CFG_COMMENT_CLOSE])
            begin
                if (depth > -128) depth--;
            end
            return;
        end
        depth = 0;
        for (k = int'(CFG_GROUP_OPEN); k <= int'(CFG_LIST_CLOSE); k++)
        begin
            if (b == cfg_chr[k])
            begin
                emit_tok(KIND_GROUP_OPEN + 4'(k - int'(CFG_GROUP_OPEN)), 8'h00, 0, 1'b0);
                return;
            end
        end
        if (b == CH_DQUOTE)
        begin
            mode    = LEX_QUOTED;
            esc     = 1'b0;
            tok_len = 0;
        end
        else if (bare_ok(b))
        begin
            mode    = LEX_BARE;
            tok_len = 0;
            keep_body(b);
        end
        else
        begin
            emit_tok(KIND_BAD_CHAR, b, 0, 1'b0);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] b, input logic fin);
        tok_t t;
        step_res.delete();
        if (b == CH_LF && line_cnt < int'(LINE_MAX)) line_cnt++;
        case (mode)
            LEX_QUOTED:
            begin
                if (!esc && b == CH_DQUOTE)
                begin
                    close_string();
                end
                else
                begin
                    esc = (b == CH_BSLASH);
                    if (!esc) keep_body(b);
                end
            end
            LEX_BARE:
            begin
                if (bare_ok(b))
                begin
                    keep_body(b);
                end
                else
                begin
                    close_string();
                    token_start(b);
                end
            end
            default: token_start(b);
        endcase
        if (fin)
        begin
            if (mode == LEX_BARE) close_string();
            else if (mode == LEX_QUOTED) emit_tok(KIND_UNTERM, 8'h00, 0, 1'b0);
            emit_tok(KIND_END, 8'h00, 0, 1'b0);
            mode     = LEX_GAP;
            esc      = 1'b0;
            depth    = 0;
            tok_len  = 0;
            line_cnt = 1;
        end
        if (step_res.size() != 0)
        begin
            t = step_res[$];
            t.last = 1'b1;
            step_res[$] = t;
        end
    endfunction

    // ---------------- checking ----------------

    function automatic void check_tok(input tok_t e);
        if (token_kind !== e.kind)
        begin
            $error("token_kind: expected %0d, got %0d", e.kind, token_kind);
            fail_cnt++;
        end
        if (body_byte !== e.body)
        begin
            $error("body_byte: expected %0h, got %0h", e.body, body_byte);
            fail_cnt++;
        end
        if (string_length !== e.len)
        begin
            $error("string_length: expected %0d, got %0d", e.len, string_length);
            fail_cnt++;
        end
        if (truncated !== e.trunc)
        begin
            $error("truncated: expected %0b, got %0b", e.trunc, truncated);
            fail_cnt++;
        end
        if (line_number !== e.line)
        begin
            $error("line_number: expected %0d, got %0d", e.line, line_number);
            fail_cnt++;
        end
        if (run_end !== e.last)
        begin
            $error("run_end: expected %0b, got %0b", e.last, run_end);
            fail_cnt++;
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin : mon
        tok_t t;
        if (rst_n)
        begin
            if (token_valid && !token_stall)
            begin
                if (token_q.size() == 0)
                begin
                    $error("token with nothing pending: kind %0d", token_kind);
                    fail_cnt++;
                end
                else
                begin
                    check_tok(token_q.pop_front());
                end
            end
            if (text_valid && !text_stall)
            begin
                lex_byte(text_byte, final_byte);
                if (pin_typed && step_res.size() != 0)
                begin
                    t = step_res[0];
                    t.kind = pin_kind;
                    t.body = pin_body;
                    step_res[0] = t;
                end
                foreach (step_res[i]) token_q.push_back(step_res[i]);
            end
        end
        // output back-pressure: a stall burst, then a free run
        if (free_left == 0 && hold_left == 0)
        begin
            free_left = $urandom_range(1, 16);
            hold_left = no_idle ? 0 : gap_len();
        end
        if (hold_left != 0)
        begin
            hold_left--;
            token_stall <= 1'b1;
        end
        else
        begin
            free_left--;
            token_stall <= 1'b0;
        end
    end

    // ---------------- stimulus ----------------

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [3:0] kind, input logic [7:0] body);
        int gap;
        gap = no_idle ? 0 : gap_len();
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_byte  <= b;
        final_byte <= fin;
        pin_typed  <= typed;
        pin_kind   <= kind;
        pin_body   <= body;
        @(posedge clk);
        while (text_stall) @(posedge clk);
    endtask

    // drop valid and let every pending token drain before touching registers
    task automatic settle();
        text_valid <= 1'b0;
        @(posedge clk);
        while (token_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_cfg(input logic [7:0] v [NUM_CFG]);
        for (int i = 0; i < NUM_CFG; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= v[i];
            @(posedge clk);
            cfg_chr[i] = v[i];
        end
        cfg_write <= 1'b0;
    endtask

    function automatic logic [7:0] rand_bare();
        case ($urandom_range(0, 4))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'h30 + 8'($urandom_range(0, 9));
            3: return BARE_SYMS[$urandom_range(0, 10)];
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic void add_bare(input int n);
        for (int j = 0; j < n; j++) doc_q.push_back(rand_bare());
    endfunction

    function automatic void add_quoted(input int n, input bit closed);
        int r;
        doc_q.push_back(CH_DQUOTE);
        for (int j = 0; j < n; j++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                doc_q.push_back(rand_bare());
            end
            else if (r < 75)
            begin
                doc_q.push_back(CH_BSLASH);
            end
            else if (r < 85)
            begin
                doc_q.push_back(CH_BSLASH);
                doc_q.push_back(CH_DQUOTE);
            end
            else
            begin
                doc_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (closed) doc_q.push_back(CH_DQUOTE);
    endfunction

    // well-formed token soup with some noise mixed in
    function automatic void build_doc(input int n_tok);
        logic [7:0] ws [3];
        logic [7:0] odd [5];
        ws  = '{CH_SPACE, CH_TAB, CH_LF};
        odd = '{8'h0D, 8'h7F, 8'h00, 8'hFF, 8'h22};
        doc_q.delete();
        for (int j = 0; j < n_tok; j++)
        begin
            case ($urandom_range(0, 11))
                0, 1: doc_q.push_back(ws[$urandom_range(0, 2)]);
                2:
                begin
                    doc_q.push_back(cfg_chr[CFG_COMMENT_OPEN]);
                    for (int m = $urandom_range(0, 4); m > 0; m--)
                        doc_q.push_back(8'($urandom_range(0, 255)));
                    doc_q.push_back(cfg_chr[CFG_COMMENT_CLOSE]);
                end
                3, 4: doc_q.push_back(cfg_chr[$urandom_range(int'(CFG_GROUP_OPEN),
                                                            int'(CFG_LIST_CLOSE))]);
                5, 6: add_quoted($urandom_range(0, 8), $urandom_range(0, 9) != 0);
                7, 8: add_bare($urandom_range(1, 8));
                9: doc_q.push_back(8'($urandom_range(0, 255)));
                10: doc_q.push_back(odd[$urandom_range(0, 4)]);
                default: doc_q.push_back(cfg_chr[CFG_COMMENT_CLOSE]);
            endcase
        end
        if (doc_q.size() == 0) doc_q.push_back(ws[0]);
    endfunction

    task automatic send_doc();
        for (int j = 0; j < doc_q.size(); j++)
            send_byte(doc_q[j], j == doc_q.size() - 1, 1'b0, KIND_BODY, 8'h00);
    endtask

    task automatic run_docs(input int quota);
        int sent;
        sent = 0;
        while (sent < quota)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            build_doc($urandom_range(1, 12));
            sent += doc_q.size();
            send_doc();
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        text_valid  = 1'b0;
        text_byte   = 8'h00;
        final_byte  = 1'b0;
        token_stall = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = 8'h00;
        pin_typed   = 1'b0;
        pin_kind    = KIND_BODY;
        pin_body    = 8'h00;
        fail_cnt    = 0;
        no_idle     = 1'b0;
        hold_left   = 0;
        free_left   = 0;
        cfg_chr     = CFG_RESET;
        mode        = LEX_GAP;
        esc         = 1'b0;
        depth       = 0;
        tok_len     = 0;
        line_cnt    = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_TAB[i])
            send_byte(DIR_TAB[i].b, DIR_TAB[i].fin, DIR_TAB[i].typed,
                      DIR_TAB[i].kind, DIR_TAB[i].body);
        settle();

        // default delimiters: random soup, then comment nesting past its ceiling;
        // the opening list byte stays inside the comment only if the depth held
        run_docs(60);
        doc_q.delete();
        repeat (129) doc_q.push_back(cfg_chr[CFG_COMMENT_OPEN]);
        doc_q.push_back(8'h28);
        send_doc();
        settle();

        load_cfg(CFG_EDGE);
        run_docs(40);
        settle();

        load_cfg(CFG_ALIAS);
        run_docs(40);
        settle();

        foreach (cfg_rand[i]) cfg_rand[i] = 8'($urandom_range(0, 255));
        load_cfg(cfg_rand);
        run_docs(40);
        settle();

        load_cfg(CFG_RESET);
        run_docs(15);

        settle();
        repeat (8) @(posedge clk);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
